### rtl/mlfd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the mac learning forward decision core
// no dependencies

package mlfd_pkg;

   localparam int PORT_W      = 2;
   localparam int MAC_W       = 48;
   localparam int ACT_W       = 2;
   localparam int MASK_W      = 4;
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 8;

   // ports that exist on the switch; flooding never reaches beyond them
   localparam int NUM_PORTS = 4;
   localparam logic [MASK_W-1:0] PORT_ALL =
      (NUM_PORTS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << NUM_PORTS) - 1);

   localparam logic [ACT_W-1:0] ACT_FORWARD = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DROP    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FLOOD   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic empty;
      logic last;
      logic out_free;
   } ctl_sts_type;

endpackage

### rtl/mlfd_ctrl.sv
`timescale 1ns / 1ps
// sequencer for one frame: accept, table scan, drain, decide
// depends on mlfd_pkg

module mlfd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  mlfd_pkg::ctl_sts_type sts,
   output mlfd_pkg::ctl_cmd_type cmd
);
   import mlfd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = sts.empty ? ST_DECIDE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_DRAIN: begin
            cmd = '0;
         end
         ST_DECIDE: begin
            cmd.finish = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/mlfd_dp.sv
`timescale 1ns / 1ps
// address table memory, scan compare, learn write and result register
// depends on mlfd_pkg

module mlfd_dp #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mlfd_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mlfd_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  mlfd_pkg::ctl_cmd_type               cmd,
   output mlfd_pkg::ctl_sts_type               sts
);
   import mlfd_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int ENT_W = MAC_W + PORT_W;

   logic [ENT_W-1:0] mem [TABLE_ENTRIES];

   logic [PORT_W-1:0] port_ff;
   logic [MAC_W-1:0]  src_ff;
   logic [MAC_W-1:0]  dst_ff;
   logic [IDX_W-1:0]  addr_ff;
   logic [IDX_W-1:0]  addr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [ENT_W-1:0]  rd_ff;
   logic              cmpv_ff;
   logic              src_hit_ff;
   logic              src_hit_in;
   logic              dst_hit_ff;
   logic              dst_hit_in;
   logic [PORT_W-1:0] dst_port_ff;
   logic [PORT_W-1:0] dst_port_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;

   logic [MAC_W-1:0]  rd_mac;
   logic [PORT_W-1:0] rd_port;
   logic              room;
   logic              learn;
   logic              refuse;
   logic              hit;
   logic [PORT_W-1:0] hit_port;
   logic [ACT_W-1:0]  act;
   logic [MASK_W-1:0] mask;

   assign rd_mac  = rd_ff[PORT_W +: MAC_W];
   assign rd_port = rd_ff[PORT_W-1:0];

   assign sts.empty    = (count_ff == '0);
   assign sts.last     = ((CNT_W'(addr_ff) + CNT_W'(1)) == count_ff);
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   // scan compares, first destination hit wins
   always_comb begin
      addr_in     = addr_ff;
      src_hit_in  = src_hit_ff;
      dst_hit_in  = dst_hit_ff;
      dst_port_in = dst_port_ff;
      if (cmd.load) begin
         addr_in    = '0;
         src_hit_in = 1'b0;
         dst_hit_in = 1'b0;
      end else begin
         if (cmd.scan) begin
            addr_in = addr_ff + IDX_W'(1);
         end
         if (cmpv_ff) begin
            if (rd_mac == src_ff) begin
               src_hit_in = 1'b1;
            end
            if (!dst_hit_ff && (rd_mac == dst_ff)) begin
               dst_hit_in  = 1'b1;
               dst_port_in = rd_port;
            end
         end
      end
   end

   // learn and forwarding decision
   always_comb begin
      room     = (count_ff < CNT_W'(TABLE_ENTRIES));
      learn    = !src_hit_ff && room;
      refuse   = !src_hit_ff && !room;
      // an entry appended now sits above every scanned one
      hit      = dst_hit_ff || (learn && (dst_ff == src_ff));
      hit_port = dst_hit_ff ? dst_port_ff : port_ff;
      if (hit && (hit_port != port_ff)) begin
         act  = ACT_FORWARD;
         mask = MASK_W'(1) << hit_port;
      end else if (hit) begin
         act  = ACT_DROP;
         mask = '0;
      end else begin
         act  = ACT_FLOOD;
         mask = PORT_ALL & ~(MASK_W'(1) << port_ff);
      end
      count_in     = count_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.finish) begin
         rsp_data_in  = {refuse, learn, mask, act};
         rsp_valid_in = 1'b1;
         if (learn) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && learn) begin
         mem[count_ff[IDX_W-1:0]] <= {src_ff, port_ff};
      end
      if (cmd.scan) begin
         rd_ff <= mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         port_ff <= req_tdata[PORT_W-1:0];
         src_ff  <= req_tdata[PORT_W +: MAC_W];
         dst_ff  <= req_tdata[PORT_W + MAC_W +: MAC_W];
      end
      addr_ff     <= addr_in;
      dst_port_ff <= dst_port_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmpv_ff      <= 1'b0;
         src_hit_ff   <= 1'b0;
         dst_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmpv_ff      <= cmd.scan;
         src_hit_ff   <= src_hit_in;
         dst_hit_ff   <= dst_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/mac_learning_forward_decision_core.sv
`timescale 1ns / 1ps
// top level of the mac learning switch forwarding decision
// depends on mlfd_pkg, mlfd_ctrl and mlfd_dp
//
//  channel | dir | payload
//  --------+-----+-------------------------------------------------------------
//  req_    | in  | ingress_port, source_mac, dest_mac of one received frame
//  rsp_    | out | action, egress_mask, learned, learn_refused for that frame
//
// a transaction scans the entries that the table holds when it is accepted;
// with an empty table it skips the scan and goes straight to the decide step
// the scan reads one memory entry per cycle and checks it against both addresses
// reset clears the entry count but not the table memory; no memory clearing pass is run
// the block processes one transaction at a time; a stalled result waits in the
// output register, and the decide step holds until that register is free

module mac_learning_forward_decision_core #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // [1:0] ingress_port, [49:2] source_mac, [97:50] dest_mac, [103:98] zero
   input  logic [mlfd_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [1:0] action, [5:2] egress_mask, [6] learned, [7] learn_refused
   output logic [mlfd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready
);
   import mlfd_pkg::*;

   // command and status between sequencer and datapath
   ctl_cmd_type ctl_cmd;
   ctl_sts_type ctl_sts;

   // frame sequencing
   mlfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (ctl_sts),
      .cmd        (ctl_cmd)
   );

   // table memory, compares and result register
   mlfd_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (ctl_cmd),
      .sts        (ctl_sts)
   );

   // an accepted transaction blocks the input until its result is in the output register
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted again right after a transaction");

   // the decide step always lands a result in the output register
   assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.finish |=> rsp_tvalid)
      else $error("decision did not produce a result");

   // forwarding names exactly one port
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] == ACT_FORWARD)) |-> $onehot(rsp_tdata[5:2]))
      else $error("forward result without a single egress port");

   // a dropped frame goes nowhere
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] == ACT_DROP)) |-> (rsp_tdata[5:2] == 4'd0))
      else $error("drop result with a nonzero egress mask");

endmodule
